/* src/msq_pkg.sv */
package msq_pkg;

    // Request codes as they arrive on req_type, plus the code for anything else.
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_COMMIT = 3'd1;
    localparam logic [2:0] REQ_START  = 3'd2;
    localparam logic [2:0] REQ_STOP   = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;
    localparam logic [2:0] REQ_BAD    = 3'd7;

    // Step opcodes; every code above loop end halts the program.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_KEYDOWN   = 4'd1;
    localparam logic [3:0] OP_KEYUP     = 4'd2;
    localparam logic [3:0] OP_TAP       = 4'd3;
    localparam logic [3:0] OP_PAUSE     = 4'd4;
    localparam logic [3:0] OP_USAGE     = 4'd5;
    localparam logic [3:0] OP_MOUSEMOVE = 4'd6;
    localparam logic [3:0] OP_MOUSEBTN  = 4'd7;
    localparam logic [3:0] OP_LOOPSTART = 4'd8;
    localparam logic [3:0] OP_LOOPEND   = 4'd9;

    // Event kinds of a result word.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_KEY      = 2'd1;
    localparam logic [1:0] EV_CONSUMER = 2'd2;
    localparam logic [1:0] EV_MOUSE    = 2'd3;

    // Sequencer run modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    // Width of a stored step count and of one program word.
    localparam int LEN_W  = 6;
    localparam int WORD_W = 28;

    // A classified request word on its way to the execute stage.
    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [3:0]  slot;
        logic [4:0]  step_index;
        logic [3:0]  opcode;
        logic [7:0]  arg_small;
        logic [15:0] arg_wide;
        logic [5:0]  commit_len;
        logic [31:0] now_ms;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [1:0]        event_kind;
        logic [7:0]        key_modifiers;
        logic [15:0]       key_code;
        logic              key_press;
        logic [15:0]       consumer_usage;
        logic signed [7:0] mouse_dx;
        logic signed [7:0] mouse_dy;
        logic [7:0]        mouse_buttons;
        logic              accepted;
        logic [1:0]        run_status;
        logic              last;
    } res_t;

endpackage

/* src/msq_fifo.sv */
module msq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and fill count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/msq_front.sv */
module msq_front #(
    parameter int SLOT_COUNT     = 16,
    parameter int STEPS_PER_SLOT = 32
) (
    input  logic          [2:0]  req_type,
    input  logic          [3:0]  slot,
    input  logic          [4:0]  step_index,
    input  logic          [3:0]  opcode,
    input  logic          [7:0]  arg_small,
    input  logic          [15:0] arg_wide,
    input  logic          [5:0]  commit_len,
    input  logic          [31:0] now_ms,
    output msq_pkg::cmd_t        cmd
);

    import msq_pkg::*;

    logic slot_in_range;

    assign slot_in_range = (int'(slot) < SLOT_COUNT);

    // Sort the request and settle the range checks that need no state.
    always_comb
    begin
        cmd            = '0;
        cmd.slot       = slot;
        cmd.step_index = step_index;
        cmd.opcode     = opcode;
        cmd.arg_small  = arg_small;
        cmd.arg_wide   = arg_wide;
        cmd.commit_len = commit_len;
        cmd.now_ms     = now_ms;
        case (req_type)
            REQ_WRITE:
            begin
                cmd.kind = REQ_WRITE;
                cmd.ok   = slot_in_range && (int'(step_index) < STEPS_PER_SLOT);
            end
            REQ_COMMIT:
            begin
                cmd.kind = REQ_COMMIT;
                cmd.ok   = slot_in_range && (int'(commit_len) <= STEPS_PER_SLOT);
            end
            REQ_START:
            begin
                cmd.kind = REQ_START;
                cmd.ok   = slot_in_range;
            end
            REQ_STOP:
            begin
                cmd.kind = REQ_STOP;
                cmd.ok   = 1'b1;
            end
            REQ_TICK:
            begin
                cmd.kind = REQ_TICK;
                cmd.ok   = 1'b1;
            end
            default:
            begin
                cmd.kind = REQ_BAD;
                cmd.ok   = 1'b0;
            end
        endcase
    end

endmodule

/* src/msq_exec.sv */
module msq_exec #(
    parameter int SLOT_COUNT       = 16,
    parameter int STEPS_PER_SLOT   = 32,
    parameter int LOOP_STACK_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  msq_pkg::cmd_t cmd_in,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output msq_pkg::res_t res_word
);

    import msq_pkg::*;

    localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W     = (STEPS_PER_SLOT > 1) ? $clog2(STEPS_PER_SLOT) : 1;
    localparam int PC_W      = $clog2(STEPS_PER_SLOT + 1);
    localparam int DEPTH_W   = $clog2(LOOP_STACK_DEPTH + 1);
    localparam int LS_IW     = (LOOP_STACK_DEPTH > 1) ? $clog2(LOOP_STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = SLOT_COUNT * STEPS_PER_SLOT;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W     = (PC_W > LEN_W) ? PC_W : LEN_W;

    localparam logic [1:0] ST_DISPATCH = 2'd0;
    localparam logic [1:0] ST_EXEC     = 2'd1;
    localparam logic [1:0] ST_TAP2     = 2'd2;
    localparam logic [1:0] ST_CLEAR    = 2'd3;

    // Program memory.
    logic [WORD_W-1:0]  mem [MEM_DEPTH];
    logic [WORD_W-1:0]  mem_rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [WORD_W-1:0]  mem_wdata;

    // Sequencer state.
    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    logic [SLOT_W-1:0]  cur_slot_reg;
    logic [SLOT_W-1:0]  cur_slot_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [31:0]        wake_reg;
    logic [31:0]        wake_next;
    logic [31:0]        now_reg;
    logic [31:0]        now_next;
    logic [SLOT_W-1:0]  clr_slot_reg;
    logic [SLOT_W-1:0]  clr_slot_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   clr_idx_next;
    res_t               tap_res_reg;
    res_t               tap_res_next;

    // Slot step counts.
    logic [LEN_W-1:0]   lengths_reg [SLOT_COUNT];
    logic               len_we;
    logic [SLOT_W-1:0]  len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic [SLOT_W-1:0]  len_raddr;
    logic [LEN_W-1:0]   len_rd;

    // Loop stack.
    logic [PC_W-1:0]    loop_pc_reg [LOOP_STACK_DEPTH];
    logic [15:0]        loop_cnt_reg [LOOP_STACK_DEPTH];
    logic               ls_we;
    logic [LS_IW-1:0]   ls_waddr;
    logic [PC_W-1:0]    ls_wpc;
    logic [15:0]        ls_wcnt;
    logic [DEPTH_W-1:0] depth_m1;
    logic [LS_IW-1:0]   ls_top;
    logic [PC_W-1:0]    ls_rpc;
    logic [15:0]        ls_rcnt;
    logic [15:0]        cnt_dec;

    // Request and step fields.
    logic [SLOT_W-1:0]  cmd_slot;
    logic               start_sel;
    logic [PC_W-1:0]    pc_eff;
    logic [3:0]         step_op;
    logic [7:0]         step_a0;
    logic [15:0]        step_a1;
    logic               tap_issue;

    assign cmd_slot  = SLOT_W'(cmd_in.slot);
    assign start_sel = (state_reg == ST_DISPATCH) && (cmd_in.kind == REQ_START) && cmd_in.ok;
    assign len_raddr = start_sel ? cmd_slot : cur_slot_reg;
    assign len_rd    = lengths_reg[len_raddr];
    assign depth_m1  = depth_reg - DEPTH_W'(1);
    assign ls_top    = depth_m1[LS_IW-1:0];
    assign ls_rpc    = loop_pc_reg[ls_top];
    assign ls_rcnt   = loop_cnt_reg[ls_top];
    assign cnt_dec   = ls_rcnt - 16'd1;
    assign pc_eff    = (mode_reg == MODE_WAIT) ? pc_reg + 1'b1 : pc_reg;
    assign step_op   = mem_rdata_reg[27:24];
    assign step_a0   = mem_rdata_reg[23:16];
    assign step_a1   = mem_rdata_reg[15:0];

    // Request dispatch, step execution and the commit clearing sweep.
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pc_next       = pc_reg;
        cur_slot_next = cur_slot_reg;
        depth_next    = depth_reg;
        wake_next     = wake_reg;
        now_next      = now_reg;
        clr_slot_next = clr_slot_reg;
        clr_idx_next  = clr_idx_reg;
        tap_res_next  = tap_res_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res_word      = '0;
        res_word.last = 1'b1;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = ADDR_W'(int'(cmd_in.slot) * STEPS_PER_SLOT + int'(cmd_in.step_index));
        mem_raddr     = ADDR_W'(int'(cur_slot_reg) * STEPS_PER_SLOT + int'(pc_eff));
        mem_wdata     = {cmd_in.opcode, cmd_in.arg_small, cmd_in.arg_wide};
        len_we        = 1'b0;
        len_waddr     = cmd_slot;
        len_wdata     = cmd_in.commit_len;
        ls_we         = 1'b0;
        ls_waddr      = depth_reg[LS_IW-1:0];
        ls_wpc        = pc_reg;
        ls_wcnt       = step_a1;
        tap_issue     = 1'b0;
        case (state_reg)
            ST_DISPATCH:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    res_push = 1'b1;
                    case (cmd_in.kind)
                        REQ_WRITE:
                        begin
                            if (cmd_in.ok)
                            begin
                                mem_we            = 1'b1;
                                res_word.accepted = 1'b1;
                            end
                        end
                        REQ_COMMIT:
                        begin
                            if (cmd_in.ok)
                            begin
                                len_we            = 1'b1;
                                res_word.accepted = 1'b1;
                                if (int'(cmd_in.commit_len) < STEPS_PER_SLOT)
                                begin
                                    state_next    = ST_CLEAR;
                                    clr_slot_next = cmd_slot;
                                    clr_idx_next  = IDX_W'(cmd_in.commit_len);
                                end
                            end
                        end
                        REQ_START:
                        begin
                            if (cmd_in.ok && (len_rd != '0) && (mode_reg == MODE_IDLE))
                            begin
                                cur_slot_next     = cmd_slot;
                                pc_next           = '0;
                                depth_next        = '0;
                                mode_next         = MODE_RUN;
                                res_word.accepted = 1'b1;
                            end
                        end
                        REQ_STOP:
                        begin
                            mode_next         = MODE_IDLE;
                            pc_next           = '0;
                            depth_next        = '0;
                            res_word.accepted = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            if (mode_reg == MODE_IDLE)
                            begin
                                res_word.accepted = 1'b0;
                            end
                            else if ((mode_reg == MODE_WAIT) && (cmd_in.now_ms < wake_reg))
                            begin
                                res_word.accepted = 1'b1;
                            end
                            else
                            begin
                                pc_next = pc_eff;
                                if (CMP_W'(pc_eff) >= CMP_W'(len_rd))
                                begin
                                    mode_next = MODE_IDLE;
                                end
                                else
                                begin
                                    // Fetch the step; the registered read feeds the execute state.
                                    res_push   = 1'b0;
                                    mem_re     = 1'b1;
                                    mode_next  = MODE_RUN;
                                    now_next   = cmd_in.now_ms;
                                    state_next = ST_EXEC;
                                end
                            end
                        end
                        default:
                        begin
                            res_word.accepted = 1'b0;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_DISPATCH;
                    pc_next    = pc_reg + 1'b1;
                    case (step_op)
                        OP_NOP:
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                        OP_KEYDOWN, OP_KEYUP, OP_TAP:
                        begin
                            res_word.event_kind    = EV_KEY;
                            res_word.key_modifiers = step_a0;
                            res_word.key_code      = step_a1;
                            res_word.key_press     = (step_op != OP_KEYUP);
                            if (step_op == OP_TAP)
                            begin
                                tap_issue     = 1'b1;
                                res_word.last = 1'b0;
                            end
                        end
                        OP_PAUSE:
                        begin
                            pc_next   = pc_reg;
                            wake_next = now_reg + 32'(step_a1);
                            mode_next = MODE_WAIT;
                        end
                        OP_USAGE:
                        begin
                            res_word.event_kind     = EV_CONSUMER;
                            res_word.consumer_usage = step_a1;
                        end
                        OP_MOUSEMOVE:
                        begin
                            res_word.event_kind = EV_MOUSE;
                            res_word.mouse_dx   = step_a0;
                            res_word.mouse_dy   = step_a1[7:0];
                        end
                        OP_MOUSEBTN:
                        begin
                            res_word.event_kind    = EV_MOUSE;
                            res_word.mouse_buttons = step_a0;
                        end
                        OP_LOOPSTART:
                        begin
                            // A full stack skips the push.
                            if (int'(depth_reg) < LOOP_STACK_DEPTH)
                            begin
                                ls_we      = 1'b1;
                                ls_waddr   = depth_reg[LS_IW-1:0];
                                ls_wpc     = pc_reg;
                                ls_wcnt    = step_a1;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        OP_LOOPEND:
                        begin
                            // An unmatched loop end falls through.
                            if (depth_reg != '0)
                            begin
                                if (ls_rcnt == 16'd0)
                                begin
                                    pc_next = ls_rpc + 1'b1;
                                end
                                else
                                begin
                                    ls_we    = 1'b1;
                                    ls_waddr = ls_top;
                                    ls_wpc   = ls_rpc;
                                    ls_wcnt  = cnt_dec;
                                    if (cnt_dec != 16'd0)
                                    begin
                                        pc_next = ls_rpc + 1'b1;
                                    end
                                    else
                                    begin
                                        depth_next = depth_m1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            pc_next   = pc_reg;
                            mode_next = MODE_IDLE;
                        end
                    endcase
                    if ((mode_next == MODE_RUN) && (CMP_W'(pc_next) >= CMP_W'(len_rd)))
                    begin
                        mode_next = MODE_IDLE;
                    end
                    res_word.accepted = (mode_next != MODE_IDLE);
                    if (tap_issue)
                    begin
                        state_next = ST_TAP2;
                    end
                end
            end
            ST_TAP2:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_word   = tap_res_reg;
                    state_next = ST_DISPATCH;
                end
            end
            ST_CLEAR:
            begin
                // Zero the steps at and above the committed count, one a cycle.
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(int'(clr_slot_reg) * STEPS_PER_SLOT + int'(clr_idx_reg));
                mem_wdata = '0;
                if (int'(clr_idx_reg) == STEPS_PER_SLOT - 1)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_DISPATCH;
            end
        endcase
        // Every word reports the mode after its request.
        if (state_reg != ST_TAP2)
        begin
            res_word.run_status = mode_next;
        end
        if (tap_issue)
        begin
            tap_res_next           = res_word;
            tap_res_next.key_press = 1'b0;
            tap_res_next.last      = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_DISPATCH;
            mode_reg     <= MODE_IDLE;
            pc_reg       <= '0;
            cur_slot_reg <= '0;
            depth_reg    <= '0;
            wake_reg     <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                lengths_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            pc_reg       <= pc_next;
            cur_slot_reg <= cur_slot_next;
            depth_reg    <= depth_next;
            wake_reg     <= wake_next;
            if (len_we)
            begin
                lengths_reg[len_waddr] <= len_wdata;
            end
        end
    end

    // Payload registers and the loop stack.
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        clr_slot_reg <= clr_slot_next;
        clr_idx_reg  <= clr_idx_next;
        tap_res_reg  <= tap_res_next;
        if (ls_we)
        begin
            loop_pc_reg[ls_waddr]  <= ls_wpc;
            loop_cnt_reg[ls_waddr] <= ls_wcnt;
        end
    end

    // Program memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

/* src/macro_bytecode_sequencer.sv */
// Macro sequencer: request words (write step, commit count, start, stop, tick) are
// pushed into a two-word command queue and carried out in order by the execute
// stage, whose result words wait in a two-word output queue. A tick that runs a
// step first reads the registered program memory and then executes the step in
// the execute state, and a tap gives a press word and then a release word. A commit
// of count n below STEPS_PER_SLOT then clears the slot's steps from n upward,
// keeping the execute stage busy until the clearing is done. The program memory
// needs no clearing pass after reset; the slot counts reset to zero at once.
module macro_bytecode_sequencer #(
    parameter int SLOT_COUNT       = 16,
    parameter int STEPS_PER_SLOT   = 32,
    parameter int LOOP_STACK_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic        [2:0]  req_type,
    input  logic        [3:0]  slot,
    input  logic        [4:0]  step_index,
    input  logic        [3:0]  opcode,
    input  logic        [7:0]  arg_small,
    input  logic        [15:0] arg_wide,
    input  logic        [5:0]  commit_len,
    input  logic        [31:0] now_ms,
    output logic               empty,
    input  logic               pop,
    output logic        [1:0]  event_kind,
    output logic        [7:0]  key_modifiers,
    output logic        [15:0] key_code,
    output logic               key_press,
    output logic        [15:0] consumer_usage,
    output logic signed [7:0]  mouse_dx,
    output logic signed [7:0]  mouse_dy,
    output logic        [7:0]  mouse_buttons,
    output logic               accepted,
    output logic        [1:0]  run_status,
    output logic               last
);

    import msq_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    cmd_t front_cmd;
    cmd_t queued_cmd;
    logic cmd_empty;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    res_t exec_res;
    res_t head_res;

    // Request classification.
    msq_front #(
        .SLOT_COUNT     (SLOT_COUNT),
        .STEPS_PER_SLOT (STEPS_PER_SLOT)
    ) u_front (
        .req_type   (req_type),
        .slot       (slot),
        .step_index (step_index),
        .opcode     (opcode),
        .arg_small  (arg_small),
        .arg_wide   (arg_wide),
        .commit_len (commit_len),
        .now_ms     (now_ms),
        .cmd        (front_cmd)
    );

    // Command queue between the front and the execute stage.
    msq_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .rd_en   (cmd_pop),
        .rd_data (queued_cmd),
        .full    (full),
        .empty   (cmd_empty)
    );

    // Execute stage with program memory, slot counts and loop stack.
    msq_exec #(
        .SLOT_COUNT       (SLOT_COUNT),
        .STEPS_PER_SLOT   (STEPS_PER_SLOT),
        .LOOP_STACK_DEPTH (LOOP_STACK_DEPTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (queued_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (exec_res)
    );

    // Result queue toward the consumer.
    msq_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (exec_res),
        .rd_en   (pop),
        .rd_data (head_res),
        .full    (res_full),
        .empty   (empty)
    );

    assign event_kind     = head_res.event_kind;
    assign key_modifiers  = head_res.key_modifiers;
    assign key_code       = head_res.key_code;
    assign key_press      = head_res.key_press;
    assign consumer_usage = head_res.consumer_usage;
    assign mouse_dx       = head_res.mouse_dx;
    assign mouse_dy       = head_res.mouse_dy;
    assign mouse_buttons  = head_res.mouse_buttons;
    assign accepted       = head_res.accepted;
    assign run_status     = head_res.run_status;
    assign last           = head_res.last;

    // The execute stage never writes a full result queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    // The execute stage only takes a command that is there.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    // A word that is not the last of its request is always a tap press.
    a_tap_press: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !exec_res.last) |-> (exec_res.key_press && (exec_res.event_kind == EV_KEY)))
        else $error("non-final result word is not a key press");

    // No new command starts between the press and the release of a tap.
    a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !exec_res.last) |=> !cmd_pop)
        else $error("command taken before tap release word");

endmodule
